// File: design/fpa_pkg.sv
// Shared definitions for the fixed-point ALU: format constants, opcodes,
// the item record that travels down the pipeline and the saturation helper.
// No dependencies.
package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    // Width of the scaled dividend and of the full quotient.
    localparam int DW            = 32 + FRACTION_BITS;
    // Pipeline registers ahead of the output stage: front, two multiply, DW divide steps.
    localparam int NPIPE         = DW + 3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } t_op;

    // What work is still pending on an item.
    typedef enum logic [1:0] {
        K_SIMPLE,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic signed [31:0] res;
        logic               cmp;
        logic               ovf;
        logic               dbz;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic [63:0]        prod;
        logic [31:0]        rem;
        logic [DW-1:0]      w;
    } t_item;

    typedef struct packed {
        logic signed [31:0] res;
        logic               cmp;
        logic               ovf;
        logic               dbz;
    } t_res;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] res;
    } t_sat;

    // Apply a sign to a magnitude and clamp it to the signed 32-bit range.
    function automatic t_sat sat_mag(input logic [63:0] m, input logic neg);
        t_sat s;
        logic big;
        big   = neg ? (m > 64'h0000_0000_8000_0000) : (m > 64'h0000_0000_7FFF_FFFF);
        s.ovf = big;
        if (big) begin
            s.res = neg ? S32_MIN : S32_MAX;
        end else begin
            s.res = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
        end
        return s;
    endfunction

endpackage

// File: design/fpa_front.sv
// First pipeline stage: opcode decode, the results of all operations other
// than multiply and divide, and their operand magnitudes. Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output t_item              o_item
);

    t_item              r_item;
    t_item              n_item;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic               lt;
    logic               gt;
    logic               eq;
    logic               from_ovf;

    assign sum      = {i_a[31], i_a} + {i_b[31], i_b};
    assign dif      = {i_a[31], i_a} - {i_b[31], i_b};
    assign ma       = i_a[31] ? unsigned'(~i_a + 32'sd1) : unsigned'(i_a);
    assign mb       = i_b[31] ? unsigned'(~i_b + 32'sd1) : unsigned'(i_b);
    assign lt       = i_a < i_b;
    assign gt       = i_a > i_b;
    assign eq       = i_a == i_b;
    // Shifting left overflows unless the sign bit and the bits shifted out agree.
    assign from_ovf = i_b[31:31-FRACTION_BITS] != {(FRACTION_BITS+1){i_b[31]}};

    always_comb begin
        n_item      = '0;
        n_item.kind = K_SIMPLE;
        n_item.neg  = i_a[31] ^ i_b[31];
        n_item.ma   = ma;
        n_item.mb   = mb;
        n_item.w    = {ma, {FRACTION_BITS{1'b0}}};
        case (i_op)
            OP_ADD: begin
                if (sum[32] != sum[31]) begin
                    n_item.ovf = 1'b1;
                    n_item.res = sum[32] ? S32_MIN : S32_MAX;
                end else begin
                    n_item.res = sum[31:0];
                end
            end
            OP_SUB: begin
                if (dif[32] != dif[31]) begin
                    n_item.ovf = 1'b1;
                    n_item.res = dif[32] ? S32_MIN : S32_MAX;
                end else begin
                    n_item.res = dif[31:0];
                end
            end
            OP_MUL: begin
                n_item.kind = K_MUL;
            end
            OP_DIV: begin
                if (i_b == 32'sd0) begin
                    n_item.dbz = 1'b1;
                end else begin
                    n_item.kind = K_DIV;
                end
            end
            OP_GT:  n_item.cmp = gt;
            OP_LT:  n_item.cmp = lt;
            OP_GE:  n_item.cmp = !lt;
            OP_LE:  n_item.cmp = !gt;
            OP_EQ:  n_item.cmp = eq;
            OP_NE:  n_item.cmp = !eq;
            OP_MIN: n_item.res = lt ? i_a : i_b;
            OP_MAX: n_item.res = gt ? i_a : i_b;
            OP_INC: begin
                if (i_a == S32_MAX) begin
                    n_item.ovf = 1'b1;
                    n_item.res = S32_MAX;
                end else begin
                    n_item.res = i_a + 32'sd1;
                end
            end
            OP_DEC: begin
                if (i_a == S32_MIN) begin
                    n_item.ovf = 1'b1;
                    n_item.res = S32_MIN;
                end else begin
                    n_item.res = i_a - 32'sd1;
                end
            end
            OP_TOINT: n_item.res = i_a >>> FRACTION_BITS;
            OP_FROMINT: begin
                if (from_ovf) begin
                    n_item.ovf = 1'b1;
                    n_item.res = i_b[31] ? S32_MIN : S32_MAX;
                end else begin
                    n_item.res = i_b <<< FRACTION_BITS;
                end
            end
            default: n_item.res = 32'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: design/fpa_mul.sv
// Two multiply stages: the unsigned magnitude product, then the fraction
// shift with sign and saturation. Depends on fpa_pkg.
module fpa_mul import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_item i_item,
    output t_item o_item
);

    t_item r_prod_item;
    t_item n_prod_item;
    t_item r_fix_item;
    t_item n_fix_item;
    t_sat  sat;

    always_comb begin
        n_prod_item = i_item;
        if (i_item.kind == K_MUL) begin
            n_prod_item.prod = i_item.ma * i_item.mb;
        end
    end

    assign sat = sat_mag(r_prod_item.prod >> FRACTION_BITS, r_prod_item.neg);

    always_comb begin
        n_fix_item = r_prod_item;
        if (r_prod_item.kind == K_MUL) begin
            n_fix_item.res  = sat.res;
            n_fix_item.ovf  = sat.ovf;
            n_fix_item.kind = K_SIMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_item <= n_prod_item;
            r_fix_item  <= n_fix_item;
        end
    end

    assign o_item = r_fix_item;

endmodule

// File: design/fpa_div_step.sv
// One restoring-division stage: brings down one dividend bit and produces
// one quotient bit. Depends on fpa_pkg.
module fpa_div_step import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_item i_item,
    output t_item o_item
);

    t_item       r_item;
    t_item       n_item;
    logic [32:0] part;
    logic [32:0] diff;

    assign part = {i_item.rem, i_item.w[DW-1]};
    assign diff = part - {1'b0, i_item.mb};

    // The dividend shifts out of the top of w while the quotient shifts in below.
    always_comb begin
        n_item = i_item;
        if (i_item.kind == K_DIV) begin
            if (!diff[32]) begin
                n_item.rem = diff[31:0];
                n_item.w   = {i_item.w[DW-2:0], 1'b1};
            end else begin
                n_item.rem = part[31:0];
                n_item.w   = {i_item.w[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: design/fpa_out.sv
// Output stage: signs and saturates the quotient, then holds results in an
// output register backed by a skid register. Depends on fpa_pkg.
module fpa_out import fpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_advance,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_result,
    output logic               o_compare_true,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);

    t_sat sat;
    t_res n_res;
    t_res r_out;
    t_res r_skid;
    logic r_out_v;
    logic r_skid_v;
    logic xfer;

    assign sat = sat_mag({{(64-DW){1'b0}}, i_item.w}, i_item.neg);

    always_comb begin
        n_res.res = i_item.res;
        n_res.cmp = i_item.cmp;
        n_res.ovf = i_item.ovf;
        n_res.dbz = i_item.dbz;
        if (i_item.kind == K_DIV) begin
            n_res.res = sat.res;
            n_res.ovf = sat.ovf;
        end
    end

    assign xfer = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (xfer) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || xfer) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (xfer) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || xfer) begin
            r_out <= n_res;
        end else begin
            r_skid <= n_res;
        end
    end

    assign o_advance        = !r_skid_v;
    assign o_valid          = r_out_v;
    assign o_result         = r_out.res;
    assign o_compare_true   = r_out.cmp;
    assign o_overflow       = r_out.ovf;
    assign o_divide_by_zero = r_out.dbz;

endmodule

// File: design/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
// Depends on fpa_pkg, fpa_front, fpa_mul, fpa_div_step and fpa_out.
//
// Usage
// The input channel (i_valid, o_stall) carries an opcode and two raw 32-bit
// operands with FRACTION_BITS fraction bits; the output channel (o_valid,
// i_stall) carries the result word and the compare, overflow and
// divide-by-zero flags. A transfer happens on a rising edge with valid high
// and stall low.
// Every operation takes the same path, so results leave in input order.
// One transfer can be accepted every clock cycle while o_stall is low. A
// result passes through one decode stage, two multiply stages, one
// restoring division stage per quotient bit (32 + FRACTION_BITS of them)
// and the output register. With the default Q24.8 format the division
// chain makes up most of the pipeline depth.
// When the receiver stalls, the next finished result drops into a skid
// register and the pipeline keeps taking input until that register is full;
// only then is o_stall raised and the whole pipeline holds, nothing lost.
// A synchronous active-low reset clears every valid bit, the skid register's
// included; data registers are not reset. There is no start-up sweep.
module fixed_point_alu import fpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result,
    output logic               o_compare_true,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);

    // Valid bit of each pipeline register, travelling with its data.
    logic [NPIPE-1:0] r_v;
    logic             adv;
    t_item            w_front;
    t_item            w_mul;
    t_item            w_div [DW];

    assign o_stall = !adv;

    // The whole pipeline moves together; bubbles shift like items do.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NPIPE-2:0], i_valid};
        end
    end

    fpa_front u_front (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_op   (i_op),
        .i_a    (i_a),
        .i_b    (i_b),
        .o_item (w_front)
    );

    fpa_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_item (w_front),
        .o_item (w_mul)
    );

    // Quotient bits, most significant first.
    for (genvar k = 0; k < DW; k++) begin : g_div
        if (k == 0) begin : g_first
            fpa_div_step u_step (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_item (w_mul),
                .o_item (w_div[k])
            );
        end else begin : g_next
            fpa_div_step u_step (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_item (w_div[k-1]),
                .o_item (w_div[k])
            );
        end
    end

    fpa_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_v[NPIPE-1]),
        .i_item           (w_div[DW-1]),
        .o_advance        (adv),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result         (o_result),
        .o_compare_true   (o_compare_true),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // The skid register only fills behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid register full while output register empty");

    // While the input side is held, no pipeline valid bit may move.
    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_v))
        else $error("pipeline moved while held");

    // A zero divisor forces a zero result and no other flag.
    a_dbz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            (o_result == 32'sd0) && !o_overflow && !o_compare_true)
        else $error("divide by zero result not clean");

    // A true comparison yields a zero result word and never saturates.
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |-> (o_result == 32'sd0) && !o_overflow)
        else $error("comparison result not clean");

endmodule

// File: tb/sv/tb_fixed_point_alu.sv
// Self-checking testbench for fixed_point_alu: directed corner cases, then
// random traffic with idle and stall cycles on both channels.
// Depends on fpa_pkg and the fixed_point_alu RTL; reads no files.
module tb_fixed_point_alu;
    import fpa_pkg::*;

    // The run is aborted well past the slowest legal run. That run is about
    // 1200 transfers, each of which can wait on idles and stalls, plus the
    // pipeline depth.
    localparam int CYCLE_LIMIT  = 200_000;
    // Once nothing is outstanding, watch the output for longer than the
    // pipeline is deep, so that a stray extra result is still caught.
    localparam int DRAIN_CYCLES = NPIPE + 16;
    localparam int REPORT_LIMIT = 10;

    localparam longint WIDE_MAX = 64'sd2147483647;
    localparam longint WIDE_MIN = -64'sd2147483648;

    // One accepted operation together with the result that it must produce.
    typedef struct {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        t_res        want;
    } t_alu_job;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [3:0]         i_op    = '0;
    logic signed [31:0] i_a     = '0;
    logic signed [31:0] i_b     = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_result;
    logic               o_compare_true;
    logic               o_overflow;
    logic               o_divide_by_zero;

    // Jobs that have been transferred in and whose results are still due,
    // oldest first. Results leave the block in input order.
    t_alu_job results_due[$];
    t_alu_job oldest_job;

    // When set, neither side inserts idle or stall cycles.
    bit steady_flow     = 1'b0;
    int transfers_in    = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int saturated_seen  = 0;
    int div_zero_seen   = 0;
    int cycle_count     = 0;

    fixed_point_alu dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_a              (i_a),
        .i_b              (i_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result         (o_result),
        .o_compare_true   (o_compare_true),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    // Clamps a wide signed value to the 32-bit range and reports whether it
    // had to be clamped.
    function automatic logic signed [31:0] clamp_to_s32(input longint v, output logic hit);
        hit = 1'b0;
        if (v > WIDE_MAX) begin
            hit = 1'b1;
            return S32_MAX;
        end
        if (v < WIDE_MIN) begin
            hit = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    // Works out what the ALU must return for one operation. Multiply and
    // divide run on magnitudes so that both truncate towards zero, and the
    // sign is put back before saturation.
    function automatic t_res fixed_point_result(input t_op op, input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        t_res        r;
        longint      sa;
        longint      sb;
        longint      wide;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] m;
        logic        hit;
        r     = '0;
        hit   = 1'b0;
        sa    = a;
        sb    = b;
        mag_a = (sa < 0) ? -sa : sa;
        mag_b = (sb < 0) ? -sb : sb;
        case (op)
            OP_ADD: r.res = clamp_to_s32(sa + sb, hit);
            OP_SUB: r.res = clamp_to_s32(sa - sb, hit);
            OP_MUL: begin
                m     = (mag_a * mag_b) >> FRACTION_BITS;
                wide  = ((sa < 0) != (sb < 0)) ? -$signed(m) : $signed(m);
                r.res = clamp_to_s32(wide, hit);
            end
            OP_DIV: begin
                if (sb == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    m     = (mag_a << FRACTION_BITS) / mag_b;
                    wide  = ((sa < 0) != (sb < 0)) ? -$signed(m) : $signed(m);
                    r.res = clamp_to_s32(wide, hit);
                end
            end
            OP_GT:    r.cmp = (a > b);
            OP_LT:    r.cmp = (a < b);
            OP_GE:    r.cmp = (a >= b);
            OP_LE:    r.cmp = (a <= b);
            OP_EQ:    r.cmp = (a == b);
            OP_NE:    r.cmp = (a != b);
            OP_MIN:   r.res = (a < b) ? a : b;
            OP_MAX:   r.res = (a > b) ? a : b;
            OP_INC:   r.res = clamp_to_s32(sa + 1, hit);
            OP_DEC:   r.res = clamp_to_s32(sa - 1, hit);
            // An arithmetic shift floors, which is what to-integer asks for.
            OP_TOINT: r.res = a >>> FRACTION_BITS;
            default: begin
                m     = mag_b << FRACTION_BITS;
                wide  = (sb < 0) ? -$signed(m) : $signed(m);
                r.res = clamp_to_s32(wide, hit);
            end
        endcase
        r.ovf = hit;
        return r;
    endfunction

    // Operands are weighted towards the bounds, zero, small values, whole
    // numbers and single set bits, with fully random words for the rest.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = S32_MAX;
            1: v = S32_MIN;
            2: v = '0;
            3: v = $urandom_range(2047) - 1024;
            4: v = ($urandom_range(65535) - 32768) << FRACTION_BITS;
            5: begin
                v = 32'd1 << $urandom_range(31);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Presents one operation and holds it until the block takes it. Random
    // idle cycles go ahead of the transfer unless the flow is held steady.
    task automatic send_op(input t_op op, input logic [31:0] a, input logic [31:0] b);
        t_alu_job job;
        while (!steady_flow && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_a     <= a;
        i_b     <= b;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        job.op   = op;
        job.a    = a;
        job.b    = b;
        job.want = fixed_point_result(op, a, b);
        results_due.push_back(job);
        transfers_in++;
    endtask

    // Every opcode at least once, at the range limits and at the points where
    // saturation, truncation, ties and divide by zero show.
    task automatic test_corner_cases();
        send_op(OP_ADD, S32_MAX, 32'sd1);
        send_op(OP_ADD, S32_MIN, -32'sd1);
        send_op(OP_SUB, S32_MIN, 32'sd1);
        send_op(OP_SUB, S32_MAX, -32'sd1);
        send_op(OP_MUL, S32_MAX, S32_MAX);
        send_op(OP_MUL, S32_MIN, S32_MIN);
        // The magnitude of the product is below one LSB, so it truncates to zero.
        send_op(OP_MUL, -32'sd1, 32'sd1);
        send_op(OP_DIV, 32'sd5, 32'sd0);
        send_op(OP_DIV, S32_MIN, -32'sd1);
        send_op(OP_DIV, S32_MIN, -32'sd256);
        send_op(OP_GT, 32'sd3, -32'sd3);
        send_op(OP_LT, 32'sd3, -32'sd3);
        send_op(OP_GE, 32'sd7, 32'sd7);
        send_op(OP_LE, S32_MIN, S32_MAX);
        send_op(OP_EQ, 32'sd7, 32'sd7);
        send_op(OP_NE, 32'sd7, 32'sd7);
        send_op(OP_MIN, 32'sd4, 32'sd4);
        send_op(OP_MAX, S32_MIN, S32_MAX);
        send_op(OP_INC, S32_MAX, 32'sd0);
        send_op(OP_DEC, S32_MIN, 32'sd0);
        send_op(OP_TOINT, S32_MIN, 32'sd0);
        send_op(OP_TOINT, -32'sd1, 32'sd0);
        send_op(OP_FROMINT, 32'sd0, S32_MAX);
        send_op(OP_FROMINT, 32'sd0, S32_MIN);
    endtask

    // Random operations of every kind. Now and then b copies a so that the
    // equality comparisons and the min and max ties come up often.
    task automatic test_random_ops(input int count);
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        repeat (count) begin
            op = t_op'($urandom_range(15));
            a  = pick_operand();
            b  = ($urandom_range(4) == 0) ? a : pick_operand();
            send_op(op, a, b);
        end
    endtask

    // A long run with a transfer on every cycle that the block allows, to
    // fill the pipeline end to end.
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        test_random_ops(300);
        steady_flow = 1'b0;
    endtask

    // The bulk of the random traffic, with both sides idling and stalling.
    task automatic test_irregular_traffic();
        test_random_ops(830);
    endtask

    // The output side stalls at random, except during the steady stretch.
    // Each result transfer is compared with the oldest job still due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result transfer: result %0d cmp %b ovf %b dbz %b",
                             o_result, o_compare_true, o_overflow, o_divide_by_zero);
                end
            end else begin
                oldest_job = results_due.pop_front();
                results_checked++;
                if (o_overflow) begin
                    saturated_seen++;
                end
                if (o_divide_by_zero) begin
                    div_zero_seen++;
                end
                if (o_result !== oldest_job.want.res
                        || o_compare_true !== oldest_job.want.cmp
                        || o_overflow !== oldest_job.want.ovf
                        || o_divide_by_zero !== oldest_job.want.dbz) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Mismatch on %s a=%h b=%h: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 oldest_job.op.name(), oldest_job.a, oldest_job.b,
                                 oldest_job.want.res, oldest_job.want.cmp,
                                 oldest_job.want.ovf, oldest_job.want.dbz,
                                 o_result, o_compare_true, o_overflow, o_divide_by_zero);
                    end
                end
            end
        end
        i_stall <= !steady_flow && ($urandom_range(99) < 7);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d results still due", results_due.size());
            $display("tb_fixed_point_alu NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cases();
        test_back_to_back();
        test_irregular_traffic();
        i_valid <= 1'b0;

        // Let the pipeline empty, then keep watching for stray results.
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d operations over all sixteen opcodes and checked %0d results.",
                 transfers_in, results_checked);
        $display("Saturated results: %0d, divide by zero: %0d, mismatches: %0d.",
                 saturated_seen, div_zero_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_fixed_point_alu OK");
        end else begin
            $display("tb_fixed_point_alu NOT OK");
        end
        $finish;
    end

endmodule
